[sv/vertex_view_transform_outcodes_core_macros.svh]
// Assertion macros for the vertex view transform core.
`ifndef VERTEX_VIEW_TRANSFORM_OUTCODES_CORE_MACROS_SVH
`define VERTEX_VIEW_TRANSFORM_OUTCODES_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define VVTO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vvto assertion failed");
// Next-cycle implication.
`define VVTO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vvto assertion failed");
`else
`define VVTO_ASSERT_IMP(lbl, ante, cons)
`define VVTO_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[sv/vvto_pkg.sv]
// Constants and types for the vertex view transform core.
package vvto_pkg;

    localparam int COORD_W     = 32;
    localparam int MAT_FRAC    = 14;
    localparam int MAT_FIELD_W = 16;
    localparam int ROW_W       = 3 * MAT_FIELD_W;
    localparam int PROD_W      = COORD_W + MAT_FIELD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CLIP_W      = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_RIGHT   = 3'd0,
        REG_ROW_UP      = 3'd1,
        REG_ROW_FORWARD = 3'd2,
        REG_POS_X       = 3'd3,
        REG_POS_Y       = 3'd4,
        REG_POS_Z       = 3'd5
    } t_cfg_reg;

    // Clip code bit positions
    localparam int CLIP_RIGHT  = 0;
    localparam int CLIP_LEFT   = 1;
    localparam int CLIP_TOP    = 2;
    localparam int CLIP_BOTTOM = 3;
    localparam int CLIP_BEHIND = 4;

    typedef logic signed [COORD_W-1:0]     t_coord;
    typedef logic signed [MAT_FIELD_W-1:0] t_melem;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic [ROW_W-1:0]              t_row;

    localparam t_melem MAT_ONE = t_melem'(1 << MAT_FRAC);

    localparam t_row ROW_RIGHT_RST   = {MAT_ONE, t_melem'(0), t_melem'(0)};
    localparam t_row ROW_UP_RST      = {t_melem'(0), MAT_ONE, t_melem'(0)};
    localparam t_row ROW_FORWARD_RST = {t_melem'(0), t_melem'(0), MAT_ONE};

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam t_sum ROUND_HALF = t_sum'(1) <<< (MAT_FRAC - 1);

    // Pick matrix element col (0 = x, in the high bits) out of a packed row.
    function automatic t_melem row_elem(input t_row row, input logic [1:0] col);
        t_melem e;
        case (col)
            2'd0:    e = row[ROW_W-1 -: MAT_FIELD_W];
            2'd1:    e = row[ROW_W-1-MAT_FIELD_W -: MAT_FIELD_W];
            default: e = row[MAT_FIELD_W-1:0];
        endcase
        return e;
    endfunction

    // Clamp a shifted dot product to the coordinate range.
    function automatic t_coord sat_sum(input t_sum v);
        logic [SUM_W-COORD_W:0] top;
        t_coord r;
        top = v[SUM_W-1:COORD_W-1];
        if ((&top) || !(|top)) begin
            r = v[COORD_W-1:0];
        end else begin
            r = v[SUM_W-1] ? COORD_MIN : COORD_MAX;
        end
        return r;
    endfunction

endpackage

[sv/vertex_view_transform_outcodes_core.sv]
// View transform of world points with frustum clip codes, four-stage pipeline.
//
// Input channel: i_valid / o_stall with i_point_x/y/z (signed Q16.16). A point is taken
// on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_view_x/y/z (signed Q16.16, saturated) and
// o_clip_codes (bit0 right, bit1 left, bit2 top, bit3 bottom, bit4 behind).
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; ready is
// always high. Write only while the pipeline is empty. Indexes 6 and 7 are dropped.
// Pipeline: subtract viewer position, nine 32x16 multiplies, sum/round/clamp, clip
// compare into the output register. The stages register into r_t, r_prod, r_view and
// r_out/r_clip in that order, and o_valid is the valid bit of the last stage.
// Throughput: one point per cycle while i_stall is low; every stage advances independently,
// so bubbles close up and a stage stalls only when the stage after it is full and stalled.
// When the receiver stalls, the output holds and the stages behind it fill up before
// o_stall rises toward the sender; nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and loads an identity matrix
// and a zero viewer position.
`include "vertex_view_transform_outcodes_core_macros.svh"

module vertex_view_transform_outcodes_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [vvto_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [vvto_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [vvto_pkg::COORD_W-1:0] i_point_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [vvto_pkg::COORD_W-1:0] o_view_x,
    output logic signed [vvto_pkg::COORD_W-1:0] o_view_y,
    output logic signed [vvto_pkg::COORD_W-1:0] o_view_z,
    output logic        [vvto_pkg::CLIP_W-1:0]  o_clip_codes,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [vvto_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [vvto_pkg::ROW_W-1:0]   i_cfg_data
);
    import vvto_pkg::*;

    // configuration
    t_row   r_row [3];
    t_coord r_pos [3];

    // stage valids and stage enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // stage data
    t_coord r_t    [3];
    t_prod  r_prod [3][3];
    t_coord r_view [3];
    t_coord r_out  [3];
    logic [CLIP_W-1:0] r_clip;

    t_coord n_t    [3];
    t_prod  n_prod [3][3];
    t_coord n_view [3];
    logic [CLIP_W-1:0] n_clip;

    t_coord pt [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_RIGHT_RST;
            r_row[1] <= ROW_UP_RST;
            r_row[2] <= ROW_FORWARD_RST;
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ROW_RIGHT:   r_row[0] <= i_cfg_data;
                REG_ROW_UP:      r_row[1] <= i_cfg_data;
                REG_ROW_FORWARD: r_row[2] <= i_cfg_data;
                REG_POS_X:       r_pos[0] <= i_cfg_data[COORD_W-1:0];
                REG_POS_Y:       r_pos[1] <= i_cfg_data[COORD_W-1:0];
                REG_POS_Z:       r_pos[2] <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    assign en4 = !r_v4 || !i_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1: point minus viewer, clamped
    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;

    always_comb begin
        logic signed [COORD_W:0] d;
        for (int i = 0; i < 3; i++) begin
            d = {pt[i][COORD_W-1], pt[i]} - {r_pos[i][COORD_W-1], r_pos[i]};
            if (d[COORD_W] != d[COORD_W-1]) begin
                n_t[i] = d[COORD_W] ? COORD_MIN : COORD_MAX;
            end else begin
                n_t[i] = d[COORD_W-1:0];
            end
        end
    end

    // stage 2: nine products
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = PROD_W'(r_t[c]) * PROD_W'(row_elem(r_row[r], 2'(c)));
            end
        end
    end

    // stage 3: exact sum, round half up, clamp
    always_comb begin
        t_sum s;
        for (int r = 0; r < 3; r++) begin
            s = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1]) + SUM_W'(r_prod[r][2])
                + ROUND_HALF;
            n_view[r] = sat_sum(s >>> MAT_FRAC);
        end
    end

    // stage 4: frustum compares; x < -z is tested as x + z < 0
    always_comb begin
        logic signed [COORD_W:0] xz, yz;
        xz = {r_view[0][COORD_W-1], r_view[0]} + {r_view[2][COORD_W-1], r_view[2]};
        yz = {r_view[1][COORD_W-1], r_view[1]} + {r_view[2][COORD_W-1], r_view[2]};
        n_clip              = '0;
        n_clip[CLIP_RIGHT]  = r_view[0] > r_view[2];
        n_clip[CLIP_LEFT]   = xz[COORD_W];
        n_clip[CLIP_TOP]    = r_view[1] > r_view[2];
        n_clip[CLIP_BOTTOM] = yz[COORD_W];
        n_clip[CLIP_BEHIND] = r_view[2][COORD_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_t    <= n_t;
        if (en2) r_prod <= n_prod;
        if (en3) r_view <= n_view;
        if (en4) begin
            r_out  <= r_view;
            r_clip <= n_clip;
        end
    end

    assign o_valid      = r_v4;
    assign o_view_x     = r_out[0];
    assign o_view_y     = r_out[1];
    assign o_view_z     = r_out[2];
    assign o_clip_codes = r_clip;

    `VVTO_ASSERT_IMP(a_behind_sign, o_valid, o_clip_codes[CLIP_BEHIND] == o_view_z[COORD_W-1])
    `VVTO_ASSERT_IMP(a_lr_behind, o_valid && o_clip_codes[CLIP_RIGHT] && o_clip_codes[CLIP_LEFT], o_clip_codes[CLIP_BEHIND])
    `VVTO_ASSERT_IMP(a_tb_behind, o_valid && o_clip_codes[CLIP_TOP] && o_clip_codes[CLIP_BOTTOM], o_clip_codes[CLIP_BEHIND])
    `VVTO_ASSERT_NXT(a_s2_hold, r_v2 && !en3, r_v2 && $stable(r_prod[0][0]))
    `VVTO_ASSERT_NXT(a_s3_hold, r_v3 && !en4, r_v3 && $stable(r_view[2]))

endmodule
